// ----- sv/lct_pkg.sv -----
`default_nettype none
package lct_pkg;

	// Default number of entries in the table.
	localparam int MAX_ENTRIES_DEF = 16;

	// Width of the configuration register and its value after reset.
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Use counts saturate at this value.
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Value returned by a get that misses and by every put.
	localparam logic signed [31:0] MISS_VALUE = -32'sd1;

	// Operation codes.
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

endpackage
`default_nettype wire

// ----- sv/lfu_cache_table.sv -----
// The result of an item accepted at one edge is shown with done
// for the cycle that follows.
// Throughput: one item per cycle; busy is always low, since the key match, the
// victim search and the state update are all combinational.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) empties the table and sets the capacity to 16.
`default_nettype none
module lfu_cache_table #(
	parameter int MAX_ENTRIES = lct_pkg::MAX_ENTRIES_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           capacity_we,
	input  wire  [lct_pkg::CAP_W-1:0]     capacity_wdata,
	input  wire                           start,
	output logic                          busy,
	input  wire                           func,
	input  wire  [31:0]                   key,
	input  wire  signed [31:0]            write_value,
	output logic                          done,
	output logic                          hit,
	output logic signed [31:0]            read_value,
	output logic                          evicted,
	output logic [31:0]                   evicted_key
);
	import lct_pkg::*;

	localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNTW = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = ((CNTW > CAP_W) ? CNTW : CAP_W) + 1;
	localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_ENTRIES);

	// Table state.
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [31:0]            key_q   [MAX_ENTRIES];
	logic [31:0]            value_q [MAX_ENTRIES];
	logic [15:0]            count_q [MAX_ENTRIES];
	logic [RW-1:0]          rank_q  [MAX_ENTRIES];
	logic [CAP_W-1:0]       cap_q;

	// Next-state values.
	logic [MAX_ENTRIES-1:0] valid_d;
	logic [31:0]            key_d   [MAX_ENTRIES];
	logic [31:0]            value_d [MAX_ENTRIES];
	logic [15:0]            count_d [MAX_ENTRIES];
	logic [RW-1:0]          rank_d  [MAX_ENTRIES];

	logic [MAX_ENTRIES-1:0] match_vec;
	logic [MAX_ENTRIES-1:0] victim_vec;
	logic [MAX_ENTRIES-1:0] free_vec;
	logic [MAX_ENTRIES-1:0] slot_vec;
	logic                   is_hit;
	logic [31:0]            hit_value;
	logic [RW-1:0]          hit_rank;
	logic [RW-1:0]          victim_rank;
	logic [31:0]            victim_key;
	logic [CMPW-1:0]        fill;
	logic [CMPW-1:0]        cap_eff;
	logic                   accept;
	logic                   do_bump;
	logic                   do_insert;
	logic                   do_evict;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Key match; keys are unique among valid entries so at most one bit is set.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (key_q[i] == key);
		end
	end
	assign is_hit = |match_vec;

	// The victim beats every other valid entry: lower count, or equal count and older.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			victim_vec[i] = valid_q[i];
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (j != i && valid_q[j] && !((count_q[i] < count_q[j]) ||
						((count_q[i] == count_q[j]) && (rank_q[i] > rank_q[j])))) begin
					victim_vec[i] = 1'b0;
				end
			end
		end
	end

	// Select the fields of the matched entry and of the victim.
	always_comb begin
		hit_value   = '0;
		hit_rank    = '0;
		victim_rank = '0;
		victim_key  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_value   = hit_value   | (match_vec[i]  ? value_q[i] : 32'd0);
			hit_rank    = hit_rank    | (match_vec[i]  ? rank_q[i]  : {RW{1'b0}});
			victim_rank = victim_rank | (victim_vec[i] ? rank_q[i]  : {RW{1'b0}});
			victim_key  = victim_key  | (victim_vec[i] ? key_q[i]   : 32'd0);
		end
	end

	// Fill level against the capacity, the latter clipped to the table size.
	assign fill    = CMPW'($countones(valid_q));
	assign cap_eff = ({1'b0, cap_q} > MAX_CMP) ? MAX_CMP : CMPW'(cap_q);

	assign do_bump   = is_hit && ((func == FUNC_GET) || (cap_eff != '0));
	assign do_insert = !is_hit && (func == FUNC_PUT) && (cap_eff != '0);
	assign do_evict  = do_insert && (fill >= cap_eff);

	// The lowest free entry once the victim is gone takes the new key.
	assign free_vec = ~(valid_q & ~(do_evict ? victim_vec : {MAX_ENTRIES{1'b0}}));
	assign slot_vec = free_vec & (~free_vec + MAX_ENTRIES'(1));

	// Per-entry update.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			valid_d[i] = valid_q[i];
			key_d[i]   = key_q[i];
			value_d[i] = value_q[i];
			count_d[i] = count_q[i];
			rank_d[i]  = rank_q[i];
			if (do_bump) begin
				if (match_vec[i]) begin
					rank_d[i] = '0;
					if (count_q[i] != COUNT_MAX) begin
						count_d[i] = count_q[i] + 16'd1;
					end
					if (func == FUNC_PUT) begin
						value_d[i] = write_value;
					end
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + 1'b1;
				end
			end else if (do_insert) begin
				if (do_evict && victim_vec[i]) begin
					valid_d[i] = 1'b0;
					rank_d[i]  = '0;
				end else if (valid_q[i]) begin
					if (do_evict && (rank_q[i] > victim_rank)) begin
						rank_d[i] = rank_q[i];
					end else begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
				if (slot_vec[i]) begin
					valid_d[i] = 1'b1;
					key_d[i]   = key;
					value_d[i] = write_value;
					count_d[i] = 16'd1;
					rank_d[i]  = '0;
				end
			end
		end
	end

	// Control state: valid bits, recency ranks and capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cap_q   <= CAP_RESET;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (capacity_we) begin
				cap_q <= capacity_wdata;
			end
			if (accept) begin
				valid_q <= valid_d;
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					rank_q[i] <= rank_d[i];
				end
			end
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				key_q[i]   <= key_d[i];
				value_q[i] <= value_d[i];
				count_q[i] <= count_d[i];
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= accept;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit         <= is_hit;
			read_value  <= (is_hit && (func == FUNC_GET)) ? signed'(hit_value) : MISS_VALUE;
			evicted     <= do_evict;
			evicted_key <= do_evict ? victim_key : 32'd0;
		end
	end

endmodule
`default_nettype wire

// ----- sv/lfu_cache_table_checker.sv -----
`default_nettype none
module lfu_cache_table_sva (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire               func,
	input wire               done,
	input wire               hit,
	input wire signed [31:0] read_value,
	input wire               evicted,
	input wire [31:0]        evicted_key
);
	import lct_pkg::*;

	// Every accepted item gives exactly one result in the next cycle.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an accepted item");

	// Only a put that missed can evict; a get reports no evicted key.
	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_GET) |=> (!evicted && (evicted_key == 32'd0)))
		else $error("get evicted an entry");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> !hit && (read_value == MISS_VALUE))
		else $error("eviction on a hit");

	// A miss reads the miss value.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (read_value == MISS_VALUE))
		else $error("miss returned a value");

endmodule

bind lfu_cache_table lfu_cache_table_sva u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.func        (func),
	.done        (done),
	.hit         (hit),
	.read_value  (read_value),
	.evicted     (evicted),
	.evicted_key (evicted_key)
);
`default_nettype wire
